>>> src/gbg_pkg.sv
// Shared types, constants and arithmetic helpers for the GMP basis generator.
// Used by gbg_isqrt, gbg_cell and gmp_basis_generator_unit; no dependencies.
package gbg_pkg;

   localparam int HIST_DEPTH = 8;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
   localparam int MAX_ORDER  = 4;
   localparam int MAX_TAPS   = 4;
   localparam int CNT_W      = 3;
   localparam int TAP_W      = 2;
   localparam int DATA_W     = 26;
   localparam int MAG_W      = 16;
   localparam int SAMPLE_W   = 16;
   localparam int TERM_W     = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 3;
   localparam int ROOT_STEPS = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNED_ORDERS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGNED_TAPS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAYED_ORDERS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENVELOPE_DELAYS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAYED_TAPS    = 3'd4;

   localparam logic signed [DATA_W-1:0] DATA_LIMIT = 26'sd16777216;
   localparam logic signed [TERM_W-1:0] TERM_MAX   = 24'sd8388607;
   localparam logic signed [TERM_W-1:0] TERM_MIN   = -24'sd8388608;

   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] re;
      logic signed [DATA_W-1:0] im;
      logic [MAG_W-1:0]         mag;
      logic [CNT_W-1:0]         cnt;
      logic                     last;
   } stage_type;

   function automatic logic signed [DATA_W-1:0] pow_step(
      input logic signed [DATA_W-1:0] p,
      input logic [MAG_W-1:0]         mag
   );
      logic signed [DATA_W+MAG_W:0] prod;
      logic signed [DATA_W+MAG_W:0] shifted;
      logic signed [DATA_W-1:0]     res;
      prod    = p * $signed({1'b0, mag});
      shifted = (prod + 43'sd8192) >>> 14;
      if (shifted > 43'sd16777216) begin
         res = DATA_LIMIT;
      end else if (shifted < -43'sd16777216) begin
         res = -DATA_LIMIT;
      end else begin
         res = shifted[DATA_W-1:0];
      end
      return res;
   endfunction

   function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [DATA_W-1:0] v);
      logic signed [TERM_W-1:0] res;
      if (v > 26'sd8388607) begin
         res = TERM_MAX;
      end else if (v < -26'sd8388608) begin
         res = TERM_MIN;
      end else begin
         res = v[TERM_W-1:0];
      end
      return res;
   endfunction

endpackage

>>> src/gbg_isqrt.sv
// Iterative magnitude unit: floor(sqrt(re*re + im*im)), two bits per cycle.
// Depends on gbg_pkg.
module gbg_isqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [gbg_pkg::SAMPLE_W-1:0]   in_re,
   input  logic signed [gbg_pkg::SAMPLE_W-1:0]   in_im,
   output logic                                  done,
   output logic [gbg_pkg::MAG_W-1:0]             root
);

   typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_ITER} state_type;

   state_type                            state_ff, state_in;
   logic signed [gbg_pkg::SAMPLE_W-1:0]  re_ff, re_in, im_ff, im_in;
   logic [31:0]                          val_ff, val_in;
   logic [18:0]                          rem_ff, rem_in;
   logic [gbg_pkg::MAG_W-1:0]            root_ff, root_in;
   logic [3:0]                           cnt_ff, cnt_in;
   logic                                 done_ff, done_in;
   logic signed [31:0]                   sq_re, sq_im;
   logic [18:0]                          shifted, trial;

   always_comb begin
      state_in = state_ff;
      re_in    = re_ff;
      im_in    = im_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      sq_re    = re_ff * re_ff;
      sq_im    = im_ff * im_ff;
      shifted  = {rem_ff[16:0], val_ff[31:30]};
      trial    = {1'b0, root_ff, 2'b01};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               re_in    = in_re;
               im_in    = in_im;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            val_in   = $unsigned(sq_re) + $unsigned(sq_im);
            rem_in   = '0;
            root_in  = '0;
            cnt_in   = '0;
            state_in = ST_ITER;
         end
         ST_ITER: begin
            val_in = {val_ff[29:0], 2'b00};
            if (shifted >= trial) begin
               rem_in  = shifted - trial;
               root_in = {root_ff[gbg_pkg::MAG_W-2:0], 1'b1};
            end else begin
               rem_in  = shifted;
               root_in = {root_ff[gbg_pkg::MAG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'(gbg_pkg::ROOT_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      re_ff   <= re_in;
      im_ff   <= im_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> src/gbg_cell.sv
// One power cell: multiplies the term by the magnitude while orders remain.
// Depends on gbg_pkg.
module gbg_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  gbg_pkg::stage_type  stage_in,
   output gbg_pkg::stage_type  stage_out
);

   gbg_pkg::stage_type stage_ff, stage_nx_in;

   always_comb begin
      stage_nx_in = stage_in;
      if (stage_in.cnt != '0) begin
         stage_nx_in.re  = gbg_pkg::pow_step(stage_in.re, stage_in.mag);
         stage_nx_in.im  = gbg_pkg::pow_step(stage_in.im, stage_in.mag);
         stage_nx_in.cnt = stage_in.cnt - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_nx_in.valid;
      end
      if (advance) begin
         stage_ff.re   <= stage_nx_in.re;
         stage_ff.im   <= stage_nx_in.im;
         stage_ff.mag  <= stage_nx_in.mag;
         stage_ff.cnt  <= stage_nx_in.cnt;
         stage_ff.last <= stage_nx_in.last;
      end
   end

   assign stage_out = stage_ff;

endmodule

>>> src/gmp_basis_generator_unit.sv
// Top level of the GMP basis generator: history lines, term sequencer, cell row.
// Depends on gbg_pkg, gbg_isqrt and gbg_cell.
//
// Usage: one complex Q1.14 sample enters per req_ item (req_valid, req_stall);
// the block then sends its basis terms as rsp_ items, one per cycle while not
// stalled by rsp_stall, the final one marked by rsp_term_last. Order: aligned
// terms (order, then tap), then delayed-envelope terms (delay, order, tap).
// Path: the magnitude unit forms the sum of squares, runs its 16 root steps
// and hands the root over through its done register; the first term then
// passes the generator register, four power cells and the output register.
// An item gives 1 to 64 terms; the block takes no new sample before it is
// through with the current one. req_stall stays high until the last term of
// the current item has entered the generator register.
// Reset clears the sample and magnitude histories, loads the register
// defaults and empties the cell row. When rsp_stall is high and rsp_valid is
// high, the whole cell row and the sequencer hold; the waiting term stays on the rsp_ ports.
// Configuration through csr_we / csr_index / csr_wdata, only while idle.
module gmp_basis_generator_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [gbg_pkg::SAMPLE_W-1:0]   req_sample_re,
   input  logic signed [gbg_pkg::SAMPLE_W-1:0]   req_sample_im,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [gbg_pkg::TERM_W-1:0]     rsp_term_re,
   output logic signed [gbg_pkg::TERM_W-1:0]     rsp_term_im,
   output logic                                  rsp_term_last,
   input  logic                                  csr_we,
   input  logic [gbg_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gbg_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   typedef enum logic [1:0] {ST_IDLE, ST_ROOT, ST_EMIT} state_type;

   localparam int NCELL = gbg_pkg::MAX_ORDER;

   state_type                           state_ff, state_in;
   logic [2:0]                          ao_ff, at_ff, do_ff, dt_ff;
   logic [1:0]                          ed_ff;
   logic [31:0]                         samp_ff [gbg_pkg::HIST_DEPTH];
   logic [gbg_pkg::MAG_W-1:0]           mag_ff  [gbg_pkg::HIST_DEPTH];
   logic                                phase_ff, phase_in;
   logic [gbg_pkg::CNT_W-1:0]           k_ff, k_in;
   logic [gbg_pkg::TAP_W-1:0]           i_ff, i_in;
   logic [1:0]                          m_ff, m_in;
   gbg_pkg::stage_type                  stage0_ff, stage0_in;
   gbg_pkg::stage_type                  stage_q [NCELL+1];
   logic                                rsp_valid_ff;
   logic signed [gbg_pkg::TERM_W-1:0]   rsp_re_ff, rsp_im_ff;
   logic                                rsp_last_ff;
   logic                                accept, advance, root_done;
   logic [gbg_pkg::MAG_W-1:0]           root_val;
   logic [2:0]                          ka, la, kb, lb;
   logic                                del_en, last_term;
   logic [gbg_pkg::HIST_IDX_W-1:0]      tap_idx, mag_idx;
   logic [31:0]                         tap_word;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign advance   = !rsp_valid_ff || !rsp_stall;

   assign ka     = (ao_ff == 3'd0) ? 3'd1 : ((ao_ff > 3'(gbg_pkg::MAX_ORDER)) ?
                   3'(gbg_pkg::MAX_ORDER) : ao_ff);
   assign la     = (at_ff == 3'd0) ? 3'd1 : ((at_ff > 3'(gbg_pkg::MAX_TAPS)) ?
                   3'(gbg_pkg::MAX_TAPS) : at_ff);
   assign lb     = (dt_ff == 3'd0) ? 3'd1 : ((dt_ff > 3'(gbg_pkg::MAX_TAPS)) ?
                   3'(gbg_pkg::MAX_TAPS) : dt_ff);
   assign kb     = (do_ff > 3'(gbg_pkg::MAX_ORDER)) ? 3'(gbg_pkg::MAX_ORDER) : do_ff;
   assign del_en = (kb != 3'd0) && (ed_ff != 2'd0);

   gbg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .in_re (req_sample_re),
      .in_im (req_sample_im),
      .done  (root_done),
      .root  (root_val)
   );

   always_comb begin
      tap_idx   = gbg_pkg::HIST_IDX_W'(i_ff);
      mag_idx   = phase_ff ? (gbg_pkg::HIST_IDX_W'(i_ff) + gbg_pkg::HIST_IDX_W'(m_ff)) :
                  gbg_pkg::HIST_IDX_W'(i_ff);
      tap_word  = samp_ff[tap_idx];
      state_in  = state_ff;
      phase_in  = phase_ff;
      k_in      = k_ff;
      i_in      = i_ff;
      m_in      = m_ff;
      last_term = 1'b0;
      if (!phase_ff) begin
         last_term = ({1'b0, i_ff} == la - 3'd1) && (k_ff == ka - 3'd1) && !del_en;
      end else begin
         last_term = ({1'b0, i_ff} == lb - 3'd1) && (k_ff == kb) && (m_ff == ed_ff);
      end
      stage0_in.valid = (state_ff == ST_EMIT);
      stage0_in.re    = {{5{tap_word[15]}}, tap_word[15:0], 5'b0};
      stage0_in.im    = {{5{tap_word[31]}}, tap_word[31:16], 5'b0};
      stage0_in.mag   = mag_ff[mag_idx];
      stage0_in.cnt   = k_ff;
      stage0_in.last  = last_term;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               state_in = ST_EMIT;
               phase_in = 1'b0;
               k_in     = '0;
               i_in     = '0;
               m_in     = 2'd1;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               if (last_term) begin
                  state_in = ST_IDLE;
               end else if (!phase_ff) begin
                  if ({1'b0, i_ff} == la - 3'd1) begin
                     i_in = '0;
                     if (k_ff == ka - 3'd1) begin
                        phase_in = 1'b1;
                        k_in     = 3'd1;
                        m_in     = 2'd1;
                     end else begin
                        k_in = k_ff + 3'd1;
                     end
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end else begin
                  if ({1'b0, i_ff} == lb - 3'd1) begin
                     i_in = '0;
                     if (k_ff == kb) begin
                        k_in = 3'd1;
                        m_in = m_ff + 2'd1;
                     end else begin
                        k_in = k_ff + 3'd1;
                     end
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         phase_ff        <= 1'b0;
         k_ff            <= '0;
         i_ff            <= '0;
         m_ff            <= 2'd1;
         stage0_ff.valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         m_ff     <= m_in;
         if (advance) begin
            stage0_ff.valid <= stage0_in.valid;
         end
      end
      if (advance) begin
         stage0_ff.re   <= stage0_in.re;
         stage0_ff.im   <= stage0_in.im;
         stage0_ff.mag  <= stage0_in.mag;
         stage0_ff.cnt  <= stage0_in.cnt;
         stage0_ff.last <= stage0_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ao_ff <= 3'd2;
         at_ff <= 3'd3;
         do_ff <= 3'd2;
         ed_ff <= 2'd2;
         dt_ff <= 3'd2;
      end else if (csr_we) begin
         unique case (csr_index)
            gbg_pkg::CSR_ALIGNED_ORDERS:  ao_ff <= csr_wdata;
            gbg_pkg::CSR_ALIGNED_TAPS:    at_ff <= csr_wdata;
            gbg_pkg::CSR_DELAYED_ORDERS:  do_ff <= csr_wdata;
            gbg_pkg::CSR_ENVELOPE_DELAYS: ed_ff <= csr_wdata[1:0];
            gbg_pkg::CSR_DELAYED_TAPS:    dt_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < gbg_pkg::HIST_DEPTH; j++) begin
            samp_ff[j] <= '0;
            mag_ff[j]  <= '0;
         end
      end else if (accept) begin
         for (int j = gbg_pkg::HIST_DEPTH - 1; j > 0; j--) begin
            samp_ff[j] <= samp_ff[j-1];
            mag_ff[j]  <= mag_ff[j-1];
         end
         samp_ff[0] <= {req_sample_im, req_sample_re};
      end else if (root_done) begin
         mag_ff[0] <= root_val;
      end
   end

   assign stage_q[0] = stage0_ff;

   for (genvar c = 0; c < NCELL; c++) begin : g_cell
      gbg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .stage_in  (stage_q[c]),
         .stage_out (stage_q[c+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage_q[NCELL].valid;
      end
      if (advance) begin
         rsp_re_ff   <= gbg_pkg::sat_term(stage_q[NCELL].re);
         rsp_im_ff   <= gbg_pkg::sat_term(stage_q[NCELL].im);
         rsp_last_ff <= stage_q[NCELL].last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_term_re   = rsp_re_ff;
   assign rsp_term_im   = rsp_im_ff;
   assign rsp_term_last = rsp_last_ff;

   a_accept_to_root: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_ROOT)
      else $error("accepted item did not start the magnitude unit");

   a_root_only_waiting: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ST_ROOT)
      else $error("magnitude result arrived outside the wait state");

   a_order_bound: assert property (@(posedge clock) disable iff (reset)
      stage0_ff.valid |-> stage0_ff.cnt <= 3'(gbg_pkg::MAX_ORDER))
      else $error("term order beyond the cell row");

   a_emit_feeds_row: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && advance) |=> stage0_ff.valid)
      else $error("sequencer step lost before the cell row");

endmodule

>>> bench/tb_top.sv
// Self-checking bench for gmp_basis_generator_unit: directed and random samples
// under several register settings, checked term by term against a local predictor.
// Depends on gbg_pkg and the block's RTL only.
`timescale 1ns / 1ps
module tb_top;

   localparam int LIMIT_CYCLES = 600000;
   localparam logic [gbg_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   typedef struct {
      logic signed [gbg_pkg::TERM_W-1:0] re;
      logic signed [gbg_pkg::TERM_W-1:0] im;
      logic                              last;
   } term_type;

   typedef struct {
      logic signed [gbg_pkg::SAMPLE_W-1:0] re;
      logic signed [gbg_pkg::SAMPLE_W-1:0] im;
      bit                                  known;
      logic signed [gbg_pkg::TERM_W-1:0]   first_re;
      logic signed [gbg_pkg::TERM_W-1:0]   first_im;
   } stim_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [gbg_pkg::SAMPLE_W-1:0] req_sample_re = '0;
   logic signed [gbg_pkg::SAMPLE_W-1:0] req_sample_im = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [gbg_pkg::TERM_W-1:0] rsp_term_re;
   logic signed [gbg_pkg::TERM_W-1:0] rsp_term_im;
   logic rsp_term_last;
   logic csr_we = 0;
   logic [gbg_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [gbg_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   term_type pending_terms[$];
   term_type first_term;
   logic signed [gbg_pkg::SAMPLE_W-1:0] hist_re[gbg_pkg::HIST_DEPTH];
   logic signed [gbg_pkg::SAMPLE_W-1:0] hist_im[gbg_pkg::HIST_DEPTH];
   logic [gbg_pkg::MAG_W-1:0] hist_mag[gbg_pkg::HIST_DEPTH];
   logic [2:0] cfg_ka = 3'd2, cfg_la = 3'd3, cfg_kb = 3'd2, cfg_lb = 3'd2;
   logic [1:0] cfg_mb = 2'd2;

   int errors = 0;
   int terms_checked = 0;
   int samples_sent = 0;
   int cycles = 0;
   bit idle_on = 1;
   bit hold_request = 0;
   int long_hold = 0;
   int pause = 0;

   gmp_basis_generator_unit dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic longint int_sqrt(longint v);
      longint r;
      r = 0;
      for (int b = 15; b >= 0; b--)
         if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= (64'd1 << b);
      return r;
   endfunction

   function automatic longint raise_power(longint p, longint mag, int k);
      for (int j = 0; j < k; j++) begin
         p = (p * mag + 8192) >>> 14;
         if (p > (64'sd1 <<< 40)) p = 64'sd1 <<< 40;
         if (p < -(64'sd1 <<< 40)) p = -(64'sd1 <<< 40);
      end
      return p;
   endfunction

   function automatic logic signed [gbg_pkg::TERM_W-1:0] clip24(longint v);
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[gbg_pkg::TERM_W-1:0];
   endfunction

   function automatic int bound(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic void push_term(int tap, int mag_idx, int k);
      term_type t;
      longint mag;
      mag = mag_idx < gbg_pkg::HIST_DEPTH ? longint'(hist_mag[mag_idx]) : 0;
      t.re = clip24(raise_power(longint'(hist_re[tap]) * 32, mag, k));
      t.im = clip24(raise_power(longint'(hist_im[tap]) * 32, mag, k));
      t.last = 0;
      pending_terms.push_back(t);
   endfunction

   function automatic void gen_basis_terms(logic signed [gbg_pkg::SAMPLE_W-1:0] re,
                                           logic signed [gbg_pkg::SAMPLE_W-1:0] im);
      int ka, la, kb, lb, n_before;
      longint sq;
      n_before = pending_terms.size();
      for (int i = gbg_pkg::HIST_DEPTH - 1; i > 0; i--) begin
         hist_re[i] = hist_re[i-1];
         hist_im[i] = hist_im[i-1];
         hist_mag[i] = hist_mag[i-1];
      end
      sq = longint'(re) * re + longint'(im) * im;
      hist_re[0] = re;
      hist_im[0] = im;
      hist_mag[0] = gbg_pkg::MAG_W'(int_sqrt(sq));
      ka = bound(int'(cfg_ka), 1, gbg_pkg::MAX_ORDER);
      la = bound(int'(cfg_la), 1, gbg_pkg::MAX_TAPS);
      kb = bound(int'(cfg_kb), 0, gbg_pkg::MAX_ORDER);
      lb = bound(int'(cfg_lb), 1, gbg_pkg::MAX_TAPS);
      for (int k = 0; k < ka; k++)
         for (int i = 0; i < la; i++) push_term(i, i, k);
      for (int m = 1; m <= int'(cfg_mb); m++)
         for (int k = 1; k <= kb; k++)
            for (int i = 0; i < lb; i++) push_term(i, i + m, k);
      pending_terms[$].last = 1;
      first_term = pending_terms[n_before];
   endfunction

   task automatic write_reg(logic [gbg_pkg::CSR_IDX_W-1:0] idx,
                            logic [gbg_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
      case (idx)
         gbg_pkg::CSR_ALIGNED_ORDERS:  cfg_ka = val;
         gbg_pkg::CSR_ALIGNED_TAPS:    cfg_la = val;
         gbg_pkg::CSR_DELAYED_ORDERS:  cfg_kb = val;
         gbg_pkg::CSR_ENVELOPE_DELAYS: cfg_mb = val[1:0];
         gbg_pkg::CSR_DELAYED_TAPS:    cfg_lb = val;
         default: ;
      endcase
   endtask

   task automatic send_sample(logic signed [gbg_pkg::SAMPLE_W-1:0] re,
                              logic signed [gbg_pkg::SAMPLE_W-1:0] im);
      int gap;
      gap = idle_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_sample_re <= re;
      req_sample_im <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gen_basis_terms(re, im);
      samples_sent++;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_terms.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic signed [gbg_pkg::SAMPLE_W-1:0] rand_field();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
         default: return 16'($urandom);
      endcase
   endfunction

   always @(posedge clock) begin
      if (hold_request) begin
         long_hold = 300;
         hold_request = 0;
      end
      if (long_hold > 0) begin
         long_hold--;
         rsp_stall <= 1;
      end else if (rsp_valid && !rsp_stall) begin
         pause = idle_on ? $urandom_range(0, 11) : 0;
         rsp_stall <= (pause > 0);
      end else if (pause > 0) begin
         pause--;
         rsp_stall <= (pause > 0);
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      term_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_terms.size() == 0) begin
            $display("%0t: unexpected term re=%0d im=%0d last=%0b", $time,
                     rsp_term_re, rsp_term_im, rsp_term_last);
            errors++;
         end else begin
            want = pending_terms.pop_front();
            terms_checked++;
            if (rsp_term_re !== want.re) begin
               $display("%0t: term_re expected %0d got %0d", $time, want.re, rsp_term_re);
               errors++;
            end
            if (rsp_term_im !== want.im) begin
               $display("%0t: term_im expected %0d got %0d", $time, want.im, rsp_term_im);
               errors++;
            end
            if (rsp_term_last !== want.last) begin
               $display("%0t: term_last expected %0b got %0b", $time, want.last,
                        rsp_term_last);
               errors++;
            end
         end
      end
   end

   stim_row_type directed[12] = '{
      '{16'sd0, 16'sd0, 1, 24'sd0, 24'sd0},
      '{16'sd32767, 16'sd0, 1, 24'sd1048544, 24'sd0},
      '{-16'sd32768, -16'sd32768, 1, -24'sd1048576, -24'sd1048576},
      '{16'sd32767, -16'sd32768, 1, 24'sd1048544, -24'sd1048576},
      '{16'sd16384, 16'sd16384, 1, 24'sd524288, 24'sd524288},
      '{16'sd1, -16'sd1, 1, 24'sd32, -24'sd32},
      '{16'sd16384, 16'sd0, 0, 24'sd0, 24'sd0},
      '{-16'sd12000, 16'sd23000, 0, 24'sd0, 24'sd0},
      '{16'sd0, 16'sd32767, 1, 24'sd0, 24'sd1048544},
      '{16'sh5555, 16'shaaaa, 0, 24'sd0, 24'sd0},
      '{16'shaaaa, 16'sh5555, 0, 24'sd0, 24'sd0},
      '{-16'sd1, -16'sd1, 1, -24'sd32, -24'sd32}
   };

   logic [2:0] phase_cfg[6][5] = '{
      '{3'd4, 3'd4, 3'd4, 3'd3, 3'd4},
      '{3'd1, 3'd1, 3'd0, 3'd0, 3'd1},
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
      '{3'd7, 3'd7, 3'd7, 3'd3, 3'd7},
      '{3'd3, 3'd2, 3'd1, 3'd1, 3'd3},
      '{3'd2, 3'd4, 3'd3, 3'd2, 3'd2}
   };

   initial begin
      for (int i = 0; i < gbg_pkg::HIST_DEPTH; i++) begin
         hist_re[i] = 0;
         hist_im[i] = 0;
         hist_mag[i] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[r]) begin
         send_sample(directed[r].re, directed[r].im);
         if (directed[r].known && (first_term.re !== directed[r].first_re ||
             first_term.im !== directed[r].first_im)) begin
            $display("%0t: row %0d first term expected %0d/%0d predicted %0d/%0d", $time,
                     r, directed[r].first_re, directed[r].first_im,
                     first_term.re, first_term.im);
            errors++;
         end
      end
      for (int p = 0; p < 6; p++) begin
         drain();
         write_reg(CSR_UNUSED, 3'($urandom));
         write_reg(gbg_pkg::CSR_ALIGNED_ORDERS, phase_cfg[p][0]);
         write_reg(gbg_pkg::CSR_ALIGNED_TAPS, phase_cfg[p][1]);
         write_reg(gbg_pkg::CSR_DELAYED_ORDERS, phase_cfg[p][2]);
         write_reg(gbg_pkg::CSR_ENVELOPE_DELAYS, phase_cfg[p][3]);
         write_reg(gbg_pkg::CSR_DELAYED_TAPS, phase_cfg[p][4]);
         idle_on = (p != 4);
         if (p == 5) hold_request = 1;
         repeat (p == 0 ? 12 : 20) send_sample(rand_field(), rand_field());
      end
      drain();
      $display("Sent %0d samples over 7 register settings; %0d terms checked, %0d errors.",
               samples_sent, terms_checked, errors);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
